// ===== sv/wmrs_pkg.sv =====
// Shared types and constants for the waveform min/max/RMS summary block.
// No dependencies; every other file imports this package.
package wmrs_pkg;

   localparam int SAMPLE_BITS       = 16;
   localparam int FRAME_SAMPLES     = 256;
   localparam int FRAMES_PER_GROUP  = 256;
   localparam int MAX_BLOCK_SAMPLES = 1048576;

   // Derived widths: squares, counts and sums at each level
   localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
   localparam int FC_W   = $clog2(FRAME_SAMPLES + 1);
   localparam int FSUM_W = SQ_W + FC_W;
   localparam int GC_W   = $clog2(FRAME_SAMPLES * FRAMES_PER_GROUP + 1);
   localparam int GSF_W  = SQ_W + FC_W + $clog2(FRAMES_PER_GROUP + 1);
   localparam int BC_W   = $clog2(MAX_BLOCK_SAMPLES + 1);
   localparam int BSUM_W = SQ_W + BC_W;
   localparam int DIV_W  = (BSUM_W > GSF_W) ? BSUM_W : GSF_W;
   localparam int D_W    = BC_W;
   localparam int CNT_W  = $clog2(DIV_W + 1);
   localparam int ROOT_STEPS = SAMPLE_BITS - 1;

   localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] RMS_CAP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic [1:0] LEVEL_FRAME = 2'd0;
   localparam logic [1:0] LEVEL_GROUP = 2'd1;
   localparam logic [1:0] LEVEL_BLOCK = 2'd2;

   // One finished frame, with group and block snapshots where they close
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] fmin;
      logic signed [SAMPLE_BITS-1:0] fmax;
      logic [FSUM_W-1:0]             fsum;
      logic [FC_W-1:0]               fcount;
      logic                          group_end;
      logic signed [SAMPLE_BITS-1:0] gmin;
      logic signed [SAMPLE_BITS-1:0] gmax;
      logic                          block_end;
      logic signed [SAMPLE_BITS-1:0] bmin;
      logic signed [SAMPLE_BITS-1:0] bmax;
      logic [BSUM_W-1:0]             bsum;
      logic [BC_W-1:0]               bcount;
   } job_type;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_MUL, S_ACC, S_ROOT, S_SQRT, S_EMIT
   } back_state_type;

endpackage

// ===== sv/wmrs_front.sv =====
// Front part: takes samples, tracks min/max, square sums and counts per level.
// Depends on wmrs_pkg; pushes one job per closed frame into the queue.
module wmrs_front import wmrs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic                          end_of_block,
   input  logic                          accept,
   output logic                          push,
   output job_type                       job
);

   logic signed [SAMPLE_BITS-1:0] fmin_ff, fmax_ff, gmin_ff, gmax_ff, bmin_ff, bmax_ff;
   logic signed [SAMPLE_BITS-1:0] fmin_in, fmax_in, gmin_in, gmax_in, bmin_in, bmax_in;
   logic [FSUM_W-1:0] fsum_ff, fsum_in;
   logic [FC_W-1:0]   fcnt_ff, fcnt_in;
   logic [GC_W-1:0]   gcnt_ff, gcnt_in;
   logic [BSUM_W-1:0] bsum_ff, bsum_in;
   logic [BC_W-1:0]   bcnt_ff, bcnt_in;

   logic signed [2*SAMPLE_BITS-1:0] prod;
   logic [SQ_W-1:0] sq;
   logic blk_end, frm_end, grp_end;

   // Fold the sample into every level and decide which spans close
   always_comb begin
      prod    = (2*SAMPLE_BITS)'(sample) * (2*SAMPLE_BITS)'(sample);
      sq      = SQ_W'(prod);
      fmin_in = (sample < fmin_ff) ? sample : fmin_ff;
      fmax_in = (sample > fmax_ff) ? sample : fmax_ff;
      gmin_in = (sample < gmin_ff) ? sample : gmin_ff;
      gmax_in = (sample > gmax_ff) ? sample : gmax_ff;
      bmin_in = (sample < bmin_ff) ? sample : bmin_ff;
      bmax_in = (sample > bmax_ff) ? sample : bmax_ff;
      fsum_in = fsum_ff + FSUM_W'(sq);
      fcnt_in = fcnt_ff + 1'b1;
      bsum_in = bsum_ff + BSUM_W'(sq);
      bcnt_in = bcnt_ff + 1'b1;
      gcnt_in = gcnt_ff + GC_W'(fcnt_in);
      blk_end = end_of_block || (bcnt_in >= BC_W'(MAX_BLOCK_SAMPLES));
      frm_end = (fcnt_in >= FC_W'(FRAME_SAMPLES)) || blk_end;
      grp_end = frm_end &&
                ((gcnt_in >= GC_W'(FRAME_SAMPLES * FRAMES_PER_GROUP)) || blk_end);

      push          = accept && frm_end;
      job.fmin      = fmin_in;
      job.fmax      = fmax_in;
      job.fsum      = fsum_in;
      job.fcount    = fcnt_in;
      job.group_end = grp_end;
      job.gmin      = gmin_in;
      job.gmax      = gmax_in;
      job.block_end = blk_end;
      job.bmin      = bmin_in;
      job.bmax      = bmax_in;
      job.bsum      = bsum_in;
      job.bcount    = bcnt_in;
   end

   // Advance the accumulators, clearing each level as it closes
   always_ff @(posedge clock) begin
      if (reset) begin
         fmin_ff <= SMAX; fmax_ff <= SMIN; fsum_ff <= '0; fcnt_ff <= '0;
         gmin_ff <= SMAX; gmax_ff <= SMIN; gcnt_ff <= '0;
         bmin_ff <= SMAX; bmax_ff <= SMIN; bsum_ff <= '0; bcnt_ff <= '0;
      end else if (accept) begin
         if (frm_end) begin
            fmin_ff <= SMAX; fmax_ff <= SMIN; fsum_ff <= '0; fcnt_ff <= '0;
         end else begin
            fmin_ff <= fmin_in; fmax_ff <= fmax_in; fsum_ff <= fsum_in; fcnt_ff <= fcnt_in;
         end
         if (grp_end) begin
            gmin_ff <= SMAX; gmax_ff <= SMIN; gcnt_ff <= '0;
         end else begin
            gmin_ff <= gmin_in; gmax_ff <= gmax_in;
            if (frm_end) gcnt_ff <= gcnt_in;
         end
         if (blk_end) begin
            bmin_ff <= SMAX; bmax_ff <= SMIN; bsum_ff <= '0; bcnt_ff <= '0;
         end else begin
            bmin_ff <= bmin_in; bmax_ff <= bmax_in; bsum_ff <= bsum_in; bcnt_ff <= bcnt_in;
         end
      end
   end

endmodule

// ===== sv/wmrs_queue.sv =====
// Two-entry job queue between the front and back parts.
// Depends on wmrs_pkg for the job type.
module wmrs_queue import wmrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type    entry_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] count_ff;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ff];

   // Store on push
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_job;
   end

   // Move pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0; rd_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== sv/wmrs_back.sv =====
// Back part: per job, divides sums by counts, takes square roots, emits results.
// Depends on wmrs_pkg; one shared bit-serial divider and square-root sequencer.
module wmrs_back import wmrs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  job_type                       job,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_level,
   output logic signed [SAMPLE_BITS-1:0] rsp_min_value,
   output logic signed [SAMPLE_BITS-1:0] rsp_max_value,
   output logic [SAMPLE_BITS-1:0]        rsp_rms_value,
   output logic                          rsp_last
);

   back_state_type state_ff, state_in;
   logic [1:0]        kind_ff, kind_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [D_W-1:0]    rem_ff, rem_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [GSF_W-1:0]  prod_ff, prod_in, gsf_ff, gsf_in;
   logic [GC_W-1:0]   gcnt_ff, gcnt_in;
   logic [SQ_W-1:0]   v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [SAMPLE_BITS-1:0] rms_ff, rms_in;
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_level_ff, out_level_in;
   logic signed [SAMPLE_BITS-1:0] out_min_ff, out_min_in, out_max_ff, out_max_in;
   logic [SAMPLE_BITS-1:0] out_rms_ff, out_rms_in;
   logic              out_last_ff, out_last_in;

   logic [D_W:0]   rem_sh;
   logic           qbit;
   logic [SQ_W:0]  trial;
   logic           load;

   // Sequence divide, accumulate, root and emit for each level of a job
   always_comb begin
      state_in = state_ff; kind_in = kind_ff;
      dvd_in = dvd_ff; rem_in = rem_ff; dsr_in = dsr_ff; cnt_in = cnt_ff;
      prod_in = prod_ff; gsf_in = gsf_ff; gcnt_in = gcnt_ff;
      v_in = v_ff; r_in = r_ff; bit_in = bit_ff; rms_in = rms_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_level_in = out_level_ff; out_min_in = out_min_ff; out_max_in = out_max_ff;
      out_rms_in = out_rms_ff; out_last_in = out_last_ff;
      pop = 1'b0; load = 1'b0;
      rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
      qbit   = (rem_sh >= {1'b0, dsr_ff});
      trial  = {1'b0, r_ff} + {1'b0, bit_ff};

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               kind_in  = LEVEL_FRAME;
               dvd_in   = DIV_W'(job.fsum);
               dsr_in   = D_W'(job.fcount);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = qbit ? D_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[D_W-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], qbit};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1))
               state_in = (kind_ff == LEVEL_FRAME) ? S_MUL : S_ROOT;
         end
         S_MUL: begin
            prod_in  = GSF_W'(dvd_ff[SQ_W-1:0]) * GSF_W'(FRAME_SAMPLES);
            state_in = S_ACC;
         end
         S_ACC: begin
            gsf_in   = gsf_ff + prod_ff;
            gcnt_in  = gcnt_ff + GC_W'(job.fcount);
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (|dvd_ff[DIV_W-1:SQ_W-1]) begin
               rms_in   = RMS_CAP;
               state_in = S_EMIT;
            end else begin
               v_in     = {1'b0, dvd_ff[SQ_W-2:0]};
               r_in     = '0;
               bit_in   = SQ_W'(1) << (SQ_W - 3);
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if ({1'b0, v_ff} >= trial) begin
               v_in = v_ff - trial[SQ_W-1:0];
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_STEPS - 1)) begin
               rms_in   = r_in[SAMPLE_BITS-1:0];
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_ready) begin
               load         = 1'b1;
               out_valid_in = 1'b1;
               out_level_in = kind_ff;
               out_rms_in   = rms_ff;
               rem_in       = '0;
               cnt_in       = '0;
               case (kind_ff)
                  LEVEL_FRAME: begin
                     out_min_in  = job.fmin;
                     out_max_in  = job.fmax;
                     out_last_in = !job.group_end && !job.block_end;
                  end
                  LEVEL_GROUP: begin
                     out_min_in  = job.gmin;
                     out_max_in  = job.gmax;
                     out_last_in = !job.block_end;
                  end
                  default: begin
                     out_min_in  = job.bmin;
                     out_max_in  = job.bmax;
                     out_last_in = 1'b1;
                  end
               endcase
               if (kind_ff == LEVEL_FRAME && job.group_end) begin
                  kind_in  = LEVEL_GROUP;
                  dvd_in   = DIV_W'(gsf_ff);
                  dsr_in   = D_W'(gcnt_ff);
                  gsf_in   = '0;
                  gcnt_in  = '0;
                  state_in = S_DIV;
               end else if (kind_ff != LEVEL_BLOCK && job.block_end) begin
                  kind_in  = LEVEL_BLOCK;
                  dvd_in   = DIV_W'(job.bsum);
                  dsr_in   = D_W'(job.bcount);
                  state_in = S_DIV;
               end else begin
                  pop      = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the state register, output valid flag and group accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; out_valid_ff <= 1'b0; gsf_ff <= '0; gcnt_ff <= '0;
      end else begin
         state_ff <= state_in; out_valid_ff <= out_valid_in;
         gsf_ff <= gsf_in; gcnt_ff <= gcnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      kind_ff <= kind_in; dvd_ff <= dvd_in; rem_ff <= rem_in; dsr_ff <= dsr_in;
      cnt_ff <= cnt_in; prod_ff <= prod_in; v_ff <= v_in; r_ff <= r_in;
      bit_ff <= bit_in; rms_ff <= rms_in;
      out_level_ff <= out_level_in; out_min_ff <= out_min_in; out_max_ff <= out_max_in;
      out_rms_ff <= out_rms_in; out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_level     = out_level_ff;
   assign rsp_min_value = out_min_ff;
   assign rsp_max_value = out_max_ff;
   assign rsp_rms_value = out_rms_ff;
   assign rsp_last      = out_last_ff;

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < CNT_W'(DIV_W)) else $error("divide overran");
   a_pop_emit: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == S_EMIT && job_valid && load) else $error("pop outside emit");
   a_block_job: assert property (@(posedge clock) disable iff (reset)
      load && kind_ff == LEVEL_BLOCK |-> job.block_end && job.group_end)
      else $error("block result without block end");
   a_last_pop: assert property (@(posedge clock) disable iff (reset)
      load |-> (out_last_in == pop)) else $error("last flag and pop disagree");

endmodule

// ===== sv/waveform_min_max_rms_summary.sv =====
// Top level of the waveform min/max/RMS summary block.
// Depends on wmrs_pkg, wmrs_front, wmrs_queue and wmrs_back.
//
// Usage: samples enter on the req_ channel (valid/ready), one per cycle while
// the job queue has room. Each closed frame of 256 samples (or a short final
// frame) yields a frame result on the rsp_ channel; a closed group of 256
// frames adds a group result, and end_of_block (or the block length limit)
// adds a whole-block result. rsp_last marks the final result of one frame.
// A frame result follows the transfer of the sample that closes the frame
// through a 52-step bit-serial divide, a multiply and an accumulate step, a
// 15-step square root and an emit step; a group result and then a block
// result follow, each after its own divide, root and emit. A capped RMS
// skips the root.
// Throughput: one sample per cycle while the two-job queue has room; each
// closed frame keeps the back part busy for its divides and roots, so short
// blocks throttle the input and req_ready drops when the queue is full.
// When the receiver stalls, the result stays in the output register and the
// front keeps taking samples until the queue is full.
// Reset clears all accumulators to their empty values and drops rsp_valid.
module waveform_min_max_rms_summary import wmrs_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_end_of_block,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_level,
   output logic signed [SAMPLE_BITS-1:0] rsp_min_value,
   output logic signed [SAMPLE_BITS-1:0] rsp_max_value,
   output logic [SAMPLE_BITS-1:0]        rsp_rms_value,
   output logic                          rsp_last
);

   logic    push, pop, not_full, not_empty;
   job_type push_job, head;

   // Transfer a sample whenever the queue can take a job
   assign req_ready = not_full;

   wmrs_front u_front (
      .clock(clock), .reset(reset), .sample(req_sample),
      .end_of_block(req_end_of_block), .accept(req_valid && req_ready),
      .push(push), .job(push_job)
   );

   wmrs_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_job(push_job),
      .not_full(not_full), .pop(pop), .not_empty(not_empty), .head(head)
   );

   wmrs_back u_back (
      .clock(clock), .reset(reset), .job_valid(not_empty), .job(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_level(rsp_level),
      .rsp_min_value(rsp_min_value), .rsp_max_value(rsp_max_value),
      .rsp_rms_value(rsp_rms_value), .rsp_last(rsp_last)
   );

endmodule
